// File: hdl/sdrt_pkg.sv
// ----------------------------------------------------------------------------
// sdrt_pkg
// Shared types and constants of the standby duty ratio tracker.
// ----------------------------------------------------------------------------
package sdrt_pkg;

   localparam int TICK_W     = 32;
   localparam int CMD_W      = 2;
   localparam int PERMILLE_W = 10;
   localparam int PERCENT_W  = 7;

   // serial divider operands: numerator holds standby_total * 100
   localparam int NUM_W = TICK_W + 7;
   localparam int DEN_W = TICK_W + 1;

   localparam int PERMILLE_SCALE = 1000;
   localparam int PERCENT_SCALE  = 100;

   localparam logic [CMD_W-1:0] CMD_SUSPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESUME  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_SETUP,
      ST_FILL,
      ST_READ,
      ST_WRITE,
      ST_PERM,
      ST_AVG,
      ST_AVG_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;     // latch the accepted beat
      logic diff;        // span length, span start update
      logic setup;       // total update, paint setup
      logic fill_step;   // write one ring entry without reading it
      logic read_issue;  // read ring entry at paint pointer
      logic write_step;  // write ring entry, adjust standby count
      logic end_paint;   // ring position takes the paint pointer
      logic avg_start;   // start average percent division
      logic save_perm;
      logic save_avg;
      logic load_out;    // move both results into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic remain_zero;
      logic record_cmd;  // resume or query
      logic span_big;    // span covers the whole ring
      logic div_done;
      logic div_busy;
   } dp_status_type;

endpackage

// File: hdl/sdrt_divider.sv
// ----------------------------------------------------------------------------
// sdrt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdrt_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sdrt_pkg::NUM_W-1:0] num,
   input  logic [sdrt_pkg::DEN_W-1:0] den,
   output logic [sdrt_pkg::NUM_W-1:0] quot,
   output logic                       busy,
   output logic                       done
);
   import sdrt_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_sub;
   logic              trial_ge;

   always_comb begin
      trial     = {rem_ff, num_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = trial >= {1'b0, den_ff};

      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below den, so it fits DEN_W bits
         rem_in = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign quot = num_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// File: hdl/sdrt_datapath.sv
// ----------------------------------------------------------------------------
// sdrt_datapath
// Span bookkeeping, status ring memory, standby count and result registers.
// ----------------------------------------------------------------------------
module sdrt_datapath #(
   parameter int WINDOW = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sdrt_pkg::ctrl_cmd_type          ctl_cmd,
   output sdrt_pkg::dp_status_type         dp_status,
   input  logic [sdrt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sdrt_pkg::TICK_W-1:0]     req_now_tick,
   output logic [sdrt_pkg::PERMILLE_W-1:0] rsp_window_permille,
   output logic [sdrt_pkg::PERCENT_W-1:0]  rsp_average_percent
);
   import sdrt_pkg::*;

   localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   // per-mille by reciprocal multiply: count * 1000 * ceil(2^PM_SH / WINDOW)
   // >> PM_SH, exact for every count 0..WINDOW
   localparam int PM_SH = CNT_W + PERMILLE_W + CNT_W;
   localparam longint unsigned PM_RECIP = ((64'd1 << PM_SH) + WINDOW - 1) / WINDOW;
   localparam longint unsigned PM_MUL   = PERMILLE_SCALE * PM_RECIP;
   localparam int PM_PROD_W = PM_SH + PERMILLE_W + 1;

   // ring: 0 = standby, 1 = running
   logic              ring_mem [WINDOW];
   logic              ring_rd_ff;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] span_ff, span_in;
   logic [TICK_W-1:0] delta_ff, delta_in;
   logic [TICK_W-1:0] run_total_ff, run_total_in;
   logic [TICK_W-1:0] sby_total_ff, sby_total_in;
   logic [AW-1:0]     ring_pos_ff, ring_pos_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]  sby_cnt_ff, sby_cnt_in;
   logic              paint_ff, paint_in;
   logic              total_zero_ff, total_zero_in;
   logic [PERMILLE_W-1:0] perm_ff, perm_in;
   logic [PERCENT_W-1:0]  avg_ff, avg_in;
   logic [PERMILLE_W-1:0] rsp_perm_ff, rsp_perm_in;
   logic [PERCENT_W-1:0]  rsp_avg_ff, rsp_avg_in;

   logic [TICK_W:0]   sat_sum;
   logic [TICK_W-1:0] sat_base;
   logic [AW-1:0]     ptr_next;
   logic [PM_PROD_W-1:0] perm_full;
   logic [DEN_W-1:0]  total_sum;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [NUM_W-1:0]  div_quot;
   logic              div_busy;
   logic              div_done;
   logic              record_cmd;

   assign record_cmd = (cmd_ff == CMD_RESUME) || (cmd_ff == CMD_QUERY);
   assign ptr_next   = (ptr_ff == AW'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign perm_full  = PM_PROD_W'(sby_cnt_ff) * PM_PROD_W'(PM_MUL);
   assign total_sum  = {1'b0, sby_total_ff} + {1'b0, run_total_ff};
   assign sat_base   = (cmd_ff == CMD_QUERY) ? run_total_ff : sby_total_ff;
   assign sat_sum    = {1'b0, sat_base} + {1'b0, delta_ff};

   assign div_start = ctl_cmd.avg_start;
   assign div_num   = NUM_W'(sby_total_ff) * NUM_W'(PERCENT_SCALE);
   assign div_den   = total_sum;

   sdrt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .busy  (div_busy),
      .done  (div_done)
   );

   always_comb begin
      cmd_in        = cmd_ff;
      tick_in       = tick_ff;
      span_in       = span_ff;
      delta_in      = delta_ff;
      run_total_in  = run_total_ff;
      sby_total_in  = sby_total_ff;
      ring_pos_in   = ring_pos_ff;
      ptr_in        = ptr_ff;
      remain_in     = remain_ff;
      sby_cnt_in    = sby_cnt_ff;
      paint_in      = paint_ff;
      total_zero_in = total_zero_ff;
      perm_in       = perm_ff;
      avg_in        = avg_ff;
      rsp_perm_in   = rsp_perm_ff;
      rsp_avg_in    = rsp_avg_ff;

      if (ctl_cmd.capture) begin
         cmd_in  = req_cmd;
         tick_in = req_now_tick;
      end

      if (ctl_cmd.diff) begin
         delta_in = tick_ff - span_ff;
         if (cmd_ff == CMD_SUSPEND || record_cmd) begin
            span_in = tick_ff;
         end
      end

      if (ctl_cmd.setup) begin
         if (cmd_ff == CMD_QUERY) begin
            run_total_in = sat_sum[TICK_W] ? '1 : sat_sum[TICK_W-1:0];
         end else begin
            sby_total_in = sat_sum[TICK_W] ? '1 : sat_sum[TICK_W-1:0];
         end
         paint_in = (cmd_ff == CMD_QUERY);
         if (delta_ff >= TICK_W'(WINDOW)) begin
            // whole ring takes the span status, count is known up front
            ptr_in     = '0;
            remain_in  = CNT_W'(WINDOW);
            sby_cnt_in = (cmd_ff == CMD_QUERY) ? '0 : CNT_W'(WINDOW);
         end else begin
            ptr_in    = ring_pos_ff;
            remain_in = delta_ff[CNT_W-1:0];
         end
      end

      if (ctl_cmd.fill_step) begin
         ptr_in    = ptr_next;
         remain_in = remain_ff - 1'b1;
      end

      if (ctl_cmd.write_step) begin
         ptr_in    = ptr_next;
         remain_in = remain_ff - 1'b1;
         if (ring_rd_ff != paint_ff) begin
            sby_cnt_in = paint_ff ? sby_cnt_ff - 1'b1 : sby_cnt_ff + 1'b1;
         end
      end

      if (ctl_cmd.end_paint) begin
         ring_pos_in = ptr_ff;
      end

      if (ctl_cmd.avg_start) begin
         total_zero_in = (total_sum == '0);
      end

      if (ctl_cmd.save_perm) begin
         perm_in = perm_full[PM_SH +: PERMILLE_W];
      end

      if (ctl_cmd.save_avg) begin
         avg_in = total_zero_ff ? '0 : div_quot[PERCENT_W-1:0];
      end

      if (ctl_cmd.load_out) begin
         rsp_perm_in = perm_ff;
         rsp_avg_in  = avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff      <= '0;
         run_total_ff <= '0;
         sby_total_ff <= '0;
         ring_pos_ff  <= '0;
         ptr_ff       <= '0;
         remain_ff    <= CNT_W'(WINDOW);  // clearing pass after reset
         sby_cnt_ff   <= CNT_W'(WINDOW);
         paint_ff     <= 1'b0;
      end else begin
         span_ff      <= span_in;
         run_total_ff <= run_total_in;
         sby_total_ff <= sby_total_in;
         ring_pos_ff  <= ring_pos_in;
         ptr_ff       <= ptr_in;
         remain_ff    <= remain_in;
         sby_cnt_ff   <= sby_cnt_in;
         paint_ff     <= paint_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      tick_ff       <= tick_in;
      delta_ff      <= delta_in;
      total_zero_ff <= total_zero_in;
      perm_ff       <= perm_in;
      avg_ff        <= avg_in;
      rsp_perm_ff   <= rsp_perm_in;
      rsp_avg_ff    <= rsp_avg_in;
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.fill_step || ctl_cmd.write_step) begin
         ring_mem[ptr_ff] <= paint_ff;
      end
      if (ctl_cmd.read_issue) begin
         ring_rd_ff <= ring_mem[ptr_ff];
      end
   end

   always_comb begin
      dp_status.remain_zero = (remain_ff == '0);
      dp_status.record_cmd  = record_cmd;
      dp_status.span_big    = (delta_ff >= TICK_W'(WINDOW));
      dp_status.div_done    = div_done;
      dp_status.div_busy    = div_busy;
   end

   assign rsp_window_permille = rsp_perm_ff;
   assign rsp_average_percent = rsp_avg_ff;

endmodule

// File: hdl/sdrt_ctrl.sv
// ----------------------------------------------------------------------------
// sdrt_ctrl
// Sequencer: clearing pass, span recording, ring painting, the percent
// division and the result handshake.
// ----------------------------------------------------------------------------
module sdrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sdrt_pkg::ctrl_cmd_type  ctl_cmd,
   input  sdrt_pkg::dp_status_type dp_status
);
   import sdrt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl_cmd      = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            if (dp_status.remain_zero) begin
               ctl_cmd.end_paint = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               ctl_cmd.fill_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = ST_DIFF;
            end
         end
         ST_DIFF: begin
            ctl_cmd.diff = 1'b1;
            state_in     = dp_status.record_cmd ? ST_SETUP : ST_PERM;
         end
         ST_SETUP: begin
            ctl_cmd.setup = 1'b1;
            state_in      = dp_status.span_big ? ST_FILL : ST_READ;
         end
         ST_FILL: begin
            if (dp_status.remain_zero) begin
               ctl_cmd.end_paint = 1'b1;
               state_in          = ST_PERM;
            end else begin
               ctl_cmd.fill_step = 1'b1;
            end
         end
         ST_READ: begin
            if (dp_status.remain_zero) begin
               ctl_cmd.end_paint = 1'b1;
               state_in          = ST_PERM;
            end else begin
               ctl_cmd.read_issue = 1'b1;
               state_in           = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ctl_cmd.write_step = 1'b1;
            state_in           = ST_READ;
         end
         ST_PERM: begin
            ctl_cmd.save_perm = 1'b1;
            state_in          = ST_AVG;
         end
         ST_AVG: begin
            ctl_cmd.avg_start = 1'b1;
            state_in          = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (dp_status.div_done) begin
               ctl_cmd.save_avg = 1'b1;
               state_in         = ST_OUT;
            end
         end
         ST_OUT: begin
            // output register free, or its beat leaves this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl_cmd.load_out = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/standby_duty_ratio_tracker_core.sv
// ----------------------------------------------------------------------------
// standby_duty_ratio_tracker_core
// Standby duty ratio tracker: span totals, ring bitmap and two ratios.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one event at a time. After reset the ring memory
// is cleared one entry per cycle, and the block stalls its input meanwhile.
// An event then passes through bookkeeping (accept, span, setup for a resume
// or query only, per-mille by constant reciprocal multiply, output load),
// plus, for a resume or query, the ring painting: a read, then a write of
// the single-port ring memory per tick for a span shorter than WINDOW, or a
// write of every entry without a read when the span covers the whole ring,
// plus one 39-step run of the serial divider for the percent. The result
// sits in an output register, so the next event is taken while a result
// still waits.
module standby_duty_ratio_tracker_core #(
   parameter int WINDOW = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sdrt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sdrt_pkg::TICK_W-1:0]     req_now_tick,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sdrt_pkg::PERMILLE_W-1:0] rsp_window_permille,
   output logic [sdrt_pkg::PERCENT_W-1:0]  rsp_average_percent
);
   import sdrt_pkg::*;

   ctrl_cmd_type  ctl_cmd;
   dp_status_type dp_status;

   sdrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status)
   );

   sdrt_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl_cmd             (ctl_cmd),
      .dp_status           (dp_status),
      .req_cmd             (req_cmd),
      .req_now_tick        (req_now_tick),
      .rsp_window_permille (rsp_window_permille),
      .rsp_average_percent (rsp_average_percent)
   );

   // an accepted beat keeps the input stalled while the event is worked on
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input not stalled after accepted beat");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      ctl_cmd.load_out |-> (!rsp_valid || !rsp_stall)
   ) else $error("result loaded over a waiting beat");

   // divider is idle whenever an event can be accepted
   a_div_idle: assert property (
      @(posedge clock) disable iff (reset)
      !req_stall |-> !dp_status.div_busy
   ) else $error("divider busy while idle");

   // a division is started only while the divider is free
   a_div_start: assert property (
      @(posedge clock) disable iff (reset)
      ctl_cmd.avg_start |-> !dp_status.div_busy
   ) else $error("divider started while busy");

endmodule

// File: dv/standby_duty_ratio_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// standby_duty_ratio_tracker_core_tb
// Self-checking bench: drives suspend/resume/query events with random idle on
// both channels, predicts per-mille and percent ratios from its own model of
// the ring and span totals, and checks every result beat in order.
// ----------------------------------------------------------------------------
module standby_duty_ratio_tracker_core_tb;
   import sdrt_pkg::*;

   localparam int WINDOW = 256;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 3000;
   localparam int SETTLE_CYCLES = 800;
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [PERMILLE_W-1:0] permille;
      logic [PERCENT_W-1:0]  percent;
   } duty_ratio_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_cmd;
   logic [TICK_W-1:0]     req_now_tick;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PERMILLE_W-1:0] rsp_window_permille;
   logic [PERCENT_W-1:0]  rsp_average_percent;

   // model of the tracker state
   bit [WINDOW-1:0]   duty_ring;     // 1 = running, 0 = standby
   int unsigned       paint_pos;
   logic [TICK_W-1:0] start_tick;
   logic [TICK_W-1:0] run_ticks;
   logic [TICK_W-1:0] standby_ticks;

   duty_ratio_type    expected_ratios[$];
   int unsigned       error_count;
   longint unsigned   cycle_count;
   bit                steady_flow;
   bit                hold_request;

   standby_duty_ratio_tracker_core #(
      .WINDOW(WINDOW)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_now_tick        (req_now_tick),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_window_permille (rsp_window_permille),
      .rsp_average_percent (rsp_average_percent)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_length();
      int unsigned pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(30, 80);
   endfunction

   // apply one accepted event to the model and queue the ratios it yields
   task automatic track_duty_event(input logic [CMD_W-1:0] cmd,
                                   input logic [TICK_W-1:0] tick);
      logic [TICK_W-1:0] span;
      logic [TICK_W:0]   grown;
      logic [TICK_W-1:0] capped;
      bit                running;
      int unsigned       k;
      int unsigned       standby_entries;
      longint unsigned   both;
      duty_ratio_type    ratio;
      span = tick - start_tick;
      running = (cmd == CMD_QUERY);
      case (cmd)
         CMD_RESUME, CMD_QUERY: begin
            grown = {1'b0, running ? run_ticks : standby_ticks} + {1'b0, span};
            capped = grown[TICK_W] ? {TICK_W{1'b1}} : grown[TICK_W-1:0];
            if (running) run_ticks = capped;
            else standby_ticks = capped;
            if (span >= WINDOW) begin
               duty_ring = running ? '1 : '0;
               paint_pos = 0;
            end else begin
               for (k = 0; k < span; k++) begin
                  duty_ring[paint_pos] = running;
                  paint_pos = (paint_pos + 1) % WINDOW;
               end
            end
         end
         default: ;
      endcase
      if (cmd != CMD_UNUSED) start_tick = tick;

      standby_entries = WINDOW - $countones(duty_ring);
      ratio.permille = PERMILLE_W'((standby_entries * PERMILLE_SCALE) / WINDOW);
      both = longint'(standby_ticks) + longint'(run_ticks);
      if (both == 0) ratio.percent = '0;
      else ratio.percent = PERCENT_W'((longint'(standby_ticks) * PERCENT_SCALE) / both);
      expected_ratios.push_back(ratio);
   endtask

   task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [TICK_W-1:0] tick);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_now_tick <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_duty_event(cmd, tick);
      gap = idle_length();
      if (gap != 0) begin
         req_valid    <= 1'b0;
         req_cmd      <= CMD_W'($urandom);
         req_now_tick <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid so a held beat is not taken twice while the sender waits
   task automatic release_request_channel();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_event();
      int unsigned       pick;
      logic [CMD_W-1:0]  cmd;
      logic [TICK_W-1:0] tick;
      pick = $urandom_range(0, 99);
      if (pick < 18) cmd = CMD_SUSPEND;
      else if (pick < 56) cmd = CMD_RESUME;
      else if (pick < 94) cmd = CMD_QUERY;
      else cmd = CMD_UNUSED;
      pick = $urandom_range(0, 99);
      if (cmd == CMD_UNUSED) tick = $urandom;
      else if (cmd == CMD_SUSPEND && pick < 50) tick = $urandom;
      else if (cmd == CMD_SUSPEND && pick < 65) tick = 32'hFFFF_FFFF - $urandom_range(0, 24);
      else if (pick < 70) tick = start_tick + $urandom_range(0, 12);
      else if (pick < 82) tick = start_tick + $urandom_range(13, 120);
      else if (pick < 94) tick = start_tick + $urandom_range(WINDOW - 16, WINDOW + 16);
      else tick = start_tick + $urandom_range(0, 1 << 20);
      send_event(cmd, tick);
   endtask

   task automatic test_directed_spans();
      send_event(CMD_QUERY, 32'd0);              // empty span on empty totals
      send_event(CMD_UNUSED, 32'hFFFF_FFFF);     // ignored command
      send_event(CMD_SUSPEND, 32'd100);
      send_event(CMD_RESUME, 32'd110);
      send_event(CMD_QUERY, 32'd150);
      send_event(CMD_RESUME, 32'd150);           // zero-length span
      send_event(CMD_QUERY, 32'd406);            // exactly one window
      send_event(CMD_RESUME, 32'd661);           // one short of a window
      send_event(CMD_SUSPEND, 32'hFFFF_FFF0);
      send_event(CMD_QUERY, 32'h0000_0010);      // tick wraps past zero
      send_event(CMD_UNUSED, 32'h5555_AAAA);
      send_event(CMD_QUERY, 32'h0000_0011);
      send_event(CMD_RESUME, 32'h0000_0111);     // whole ring back to standby
   endtask

   task automatic test_random_events(input int unsigned count);
      repeat (count) random_event();
   endtask

   // receiver holds off long enough for the block to back up into req_stall
   task automatic test_output_backpressure();
      hold_request = 1'b1;
      repeat (8) random_event();
   endtask

   task automatic test_steady_stream(input int unsigned count);
      steady_flow = 1'b1;
      repeat (count) random_event();
      steady_flow = 1'b0;
   endtask

   task automatic test_drain_pause();
      repeat (20) random_event();
      release_request_channel();
      while (expected_ratios.size() != 0) @(posedge clock);
      repeat (20) random_event();
   endtask

   // run last: once saturated, the totals never leave the ceiling
   task automatic test_saturation();
      send_event(CMD_SUSPEND, 32'd0);
      send_event(CMD_RESUME, 32'hFFFF_FFFF);
      send_event(CMD_RESUME, 32'hFFFF_FFFE);     // standby total hits ceiling
      send_event(CMD_QUERY, 32'hFFFF_FFFD);
      send_event(CMD_QUERY, 32'hFFFF_FFFC);      // running total hits ceiling
      send_event(CMD_SUSPEND, 32'h8000_0000);
      send_event(CMD_RESUME, 32'h8000_0005);
   endtask

   initial begin
      int unsigned stall_len;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            stall_len = idle_length();
            if (stall_len != 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      duty_ratio_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ratios.size() == 0) begin
            $error("unexpected result beat: window_permille %0d average_percent %0d",
                   rsp_window_permille, rsp_average_percent);
            error_count++;
         end else begin
            want = expected_ratios.pop_front();
            if (rsp_window_permille !== want.permille) begin
               $error("window_permille: expected %0d, actual %0d",
                      want.permille, rsp_window_permille);
               error_count++;
            end
            if (rsp_average_percent !== want.percent) begin
               $error("average_percent: expected %0d, actual %0d",
                      want.percent, rsp_average_percent);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_SUSPEND;
      req_now_tick <= '0;
      duty_ring     = '0;
      paint_pos     = 0;
      start_tick    = '0;
      run_ticks     = '0;
      standby_ticks = '0;
      error_count   = 0;
      cycle_count   = 0;
      steady_flow   = 1'b0;
      hold_request  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_spans();
      test_random_events(450);
      test_output_backpressure();
      test_steady_stream(150);
      test_drain_pause();
      test_random_events(350);
      test_saturation();
      release_request_channel();

      while (expected_ratios.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
